FILE: hw/rtl/bitplane_rle_encoder_defines.svh
// assertion macros shared by the bit-plane run-length encoder
`ifndef BITPLANE_RLE_ENCODER_DEFINES_SVH
`define BITPLANE_RLE_ENCODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BRE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define BRE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/bre_pkg.sv
// shared types and constants of the bit-plane run-length encoder
`timescale 1ns / 1ps

package bre_pkg;

	// run coding constants
	localparam logic [6:0] RUN_CAP     = 7'd127;
	localparam logic [7:0] LONE_HEADER = 8'h01;

	// configuration port
	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 8;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_SELECT = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_BYTES   = 4'd1;

	// job queue between front and back
	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = 2;
	localparam int QCNT_BITS = 3;

	// max coded bytes one plane byte can cause
	localparam int JOB_SLOTS = 3;

	// run state
	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_ONE,
		MODE_REPEAT,
		MODE_LITERAL
	} mode_t;

	// coded bytes caused by one plane byte, offsets travel beside it
	typedef struct packed {
		logic [1:0]                     cnt;
		logic [JOB_SLOTS-1:0][7:0]      data;
		logic [JOB_SLOTS-1:0]           hdr;
	} job_t;

endpackage

FILE: hw/rtl/bre_pix_if.sv
// pixel input channel
`timescale 1ns / 1ps

interface bre_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic       plane_start;

	modport source (output valid, output pixel, output plane_start, input ready);
	modport sink (input valid, input pixel, input plane_start, output ready);
endinterface

FILE: hw/rtl/bre_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps

interface bre_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [bre_pkg::CFG_INDEX_BITS-1:0]  index;
	logic [bre_pkg::CFG_DATA_BITS-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/bre_wr_if.sv
// coded byte write channel
`timescale 1ns / 1ps

interface bre_wr_if #(
	parameter int OFFSET_BITS = 20
);
	logic                   valid;
	logic                   ready;
	logic [OFFSET_BITS-1:0] write_offset;
	logic [7:0]             write_byte;
	logic                   is_header;
	logic                   last;

	modport source (output valid, output write_offset, output write_byte,
		output is_header, output last, input ready);
	modport sink (input valid, input write_offset, input write_byte,
		input is_header, input last, output ready);
endinterface

FILE: hw/rtl/bre_front.sv
// front end: plane byte assembly and run classification
`timescale 1ns / 1ps

module bre_front #(
	parameter int MAX_LINE_BYTES = 128,
	parameter int OFFSET_BITS    = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	bre_pix_if.sink                           pix,
	input  logic [2:0]                        plane_select,
	input  logic [7:0]                        line_bytes,
	input  logic                              space_ok,
	output logic                              job_valid,
	output bre_pkg::job_t                     job,
	output logic [bre_pkg::JOB_SLOTS-1:0][OFFSET_BITS-1:0] job_off
);

	localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);
	localparam logic [OFFSET_BITS-1:0] OFF_TWO = OFFSET_BITS'(2);

	logic [2:0]             bit_count_q, bits_d, c_bits;
	logic [6:0]             byte_shift_q, shift_d, c_shift;
	logic [7:0]             byte_in_line_q, line_d, c_line;
	bre_pkg::mode_t         mode_q, mode_d, c_mode, mode_mid;
	logic [7:0]             held_q, held_d, c_held;
	logic [6:0]             run_len_q, len_d, c_len, len_mid;
	logic [OFFSET_BITS-1:0] hdr_off_q, hoff_d, c_hoff;
	logic [OFFSET_BITS-1:0] next_off_q, noff_d, c_noff, off_run;

	logic       acc, start, pbit, is_last, byte_done, eq;
	logic [7:0] pbyte, line_eff;
	logic       close_first, do_data, do_open, close_after;
	logic [1:0] put_idx;

	// one job slot per free queue entry
	assign pix.ready = space_ok;
	assign acc       = pix.valid & pix.ready;
	assign start     = pix.plane_start;

	// plane start clears state ahead of this pixel
	assign c_bits  = start ? 3'd0 : bit_count_q;
	assign c_shift = start ? 7'd0 : byte_shift_q;
	assign c_line  = start ? 8'd0 : byte_in_line_q;
	assign c_mode  = start ? bre_pkg::MODE_IDLE : mode_q;
	assign c_held  = start ? 8'd0 : held_q;
	assign c_len   = start ? 7'd0 : run_len_q;
	assign c_hoff  = start ? '0 : hdr_off_q;
	assign c_noff  = start ? '0 : next_off_q;

	// plane bit and assembled byte
	assign pbit      = pix.pixel[plane_select];
	assign pbyte     = {c_shift, pbit};
	assign byte_done = (c_bits == 3'd7);
	assign eq        = (pbyte == c_held);

	// effective line length, zero acts as one, clamped to the maximum
	always_comb begin
		if (line_bytes == 8'd0) begin
			line_eff = 8'd1;
		end else if (32'(line_bytes) > MAX_LINE_BYTES) begin
			line_eff = 8'(MAX_LINE_BYTES);
		end else begin
			line_eff = line_bytes;
		end
	end

	assign is_last = ({1'b0, c_line} + 9'd1) >= {1'b0, line_eff};

	// run classification and coded byte list
	always_comb begin
		bits_d      = bit_count_q;
		shift_d     = byte_shift_q;
		line_d      = byte_in_line_q;
		mode_d      = mode_q;
		held_d      = held_q;
		len_d       = run_len_q;
		hoff_d      = hdr_off_q;
		noff_d      = next_off_q;
		close_first = 1'b0;
		do_data     = 1'b0;
		do_open     = 1'b0;
		close_after = 1'b0;
		mode_mid    = c_mode;
		len_mid     = c_len;
		off_run     = c_noff;
		put_idx     = 2'd0;
		job         = '0;
		job_off     = '0;
		if (acc) begin
			bits_d  = c_bits + 3'd1;
			shift_d = {c_shift[5:0], pbit};
			line_d  = c_line;
			mode_d  = c_mode;
			held_d  = c_held;
			len_d   = c_len;
			hoff_d  = c_hoff;
			noff_d  = c_noff;
			if (byte_done) begin
				bits_d  = 3'd0;
				shift_d = 7'd0;
				line_d  = is_last ? 8'd0 : c_line + 8'd1;
				unique case (c_mode)
					bre_pkg::MODE_IDLE: begin
						do_open = 1'b1;
					end
					bre_pkg::MODE_ONE: begin
						do_data     = !eq;
						mode_mid    = eq ? bre_pkg::MODE_REPEAT : bre_pkg::MODE_LITERAL;
						len_mid     = 7'd2;
						close_after = is_last;
					end
					bre_pkg::MODE_REPEAT: begin
						if (!eq) begin
							close_first = 1'b1;
							do_open     = 1'b1;
						end else begin
							len_mid     = c_len + 7'd1;
							close_after = is_last || (len_mid >= bre_pkg::RUN_CAP);
						end
					end
					bre_pkg::MODE_LITERAL: begin
						if (eq) begin
							close_first = 1'b1;
							do_open     = 1'b1;
						end else begin
							do_data     = 1'b1;
							len_mid     = c_len + 7'd1;
							close_after = is_last || (len_mid >= bre_pkg::RUN_CAP);
						end
					end
				endcase
				mode_d = mode_mid;
				len_d  = len_mid;

				// header of the run that the byte ends
				if (close_first) begin
					job.data[put_idx] = {c_mode == bre_pkg::MODE_REPEAT, c_len};
					job.hdr[put_idx]  = 1'b1;
					job_off[put_idx]  = c_hoff;
					put_idx           = put_idx + 2'd1;
				end
				// literal data byte
				if (do_data) begin
					job.data[put_idx] = pbyte;
					job_off[put_idx]  = off_run;
					put_idx           = put_idx + 2'd1;
					off_run           = off_run + OFF_ONE;
					held_d            = pbyte;
				end
				// new run, header slot kept in front of its first byte
				if (do_open) begin
					job.data[put_idx] = pbyte;
					job_off[put_idx]  = off_run + OFF_ONE;
					put_idx           = put_idx + 2'd1;
					if (is_last) begin
						job.data[put_idx] = bre_pkg::LONE_HEADER;
						job.hdr[put_idx]  = 1'b1;
						job_off[put_idx]  = off_run;
						put_idx           = put_idx + 2'd1;
						mode_d            = bre_pkg::MODE_IDLE;
						len_d             = 7'd0;
					end else begin
						hoff_d = off_run;
						held_d = pbyte;
						len_d  = 7'd1;
						mode_d = bre_pkg::MODE_ONE;
					end
					off_run = off_run + OFF_TWO;
				end
				// run ends at line end or at the cap
				if (close_after) begin
					job.data[put_idx] = {mode_mid == bre_pkg::MODE_REPEAT, len_mid};
					job.hdr[put_idx]  = 1'b1;
					job_off[put_idx]  = c_hoff;
					put_idx           = put_idx + 2'd1;
					mode_d            = bre_pkg::MODE_IDLE;
					len_d             = 7'd0;
				end
				noff_d = off_run;
			end
		end
		job.cnt   = put_idx;
		job_valid = acc && byte_done && (put_idx != 2'd0);
	end

	// run state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bre_pkg::MODE_IDLE;
		end else begin
			mode_q <= mode_d;
		end
	end

	// byte assembly and run bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q    <= 3'd0;
			byte_shift_q   <= 7'd0;
			byte_in_line_q <= 8'd0;
			held_q         <= 8'd0;
			run_len_q      <= 7'd0;
			hdr_off_q      <= '0;
			next_off_q     <= '0;
		end else begin
			bit_count_q    <= bits_d;
			byte_shift_q   <= shift_d;
			byte_in_line_q <= line_d;
			held_q         <= held_d;
			run_len_q      <= len_d;
			hdr_off_q      <= hoff_d;
			next_off_q     <= noff_d;
		end
	end

endmodule

FILE: hw/rtl/bre_back.sv
// back end: job queue and one coded word per cycle output stage, held while wr.ready is low
`timescale 1ns / 1ps
`include "bitplane_rle_encoder_defines.svh"

module bre_back #(
	parameter int OFFSET_BITS = 20
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           job_valid,
	input  bre_pkg::job_t                                  job,
	input  logic [bre_pkg::JOB_SLOTS-1:0][OFFSET_BITS-1:0] job_off,
	output logic                                           space_ok,
	bre_wr_if.source                                       wr
);

	localparam int PB = bre_pkg::QPTR_BITS;
	localparam int CB = bre_pkg::QCNT_BITS;
	localparam logic [CB-1:0] QFULL = CB'(bre_pkg::QDEPTH);
	localparam logic [PB-1:0] QLAST = PB'(bre_pkg::QDEPTH - 1);

	bre_pkg::job_t                                  q_job_q [bre_pkg::QDEPTH];
	logic [bre_pkg::JOB_SLOTS-1:0][OFFSET_BITS-1:0] q_off_q [bre_pkg::QDEPTH];
	logic [PB-1:0]                                  wr_ptr_q, rd_ptr_q;
	logic [CB-1:0]                                  q_cnt_q;

	logic                                           cur_valid_q;
	bre_pkg::job_t                                  cur_job_q;
	logic [bre_pkg::JOB_SLOTS-1:0][OFFSET_BITS-1:0] cur_off_q;
	logic [1:0]                                     idx_q;

	logic out_fire, cur_done, load, is_final;

	// handshake and queue control
	assign space_ok = (q_cnt_q != QFULL);
	assign out_fire = wr.valid & wr.ready;
	assign is_final = (idx_q == (cur_job_q.cnt - 2'd1));
	assign cur_done = out_fire & is_final;
	assign load     = (q_cnt_q != '0) & (!cur_valid_q | cur_done);

	// queue storage
	always_ff @(posedge clk) begin
		if (job_valid) begin
			q_job_q[wr_ptr_q] <= job;
			q_off_q[wr_ptr_q] <= job_off;
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			if (job_valid) begin
				wr_ptr_q <= (wr_ptr_q == QLAST) ? '0 : wr_ptr_q + PB'(1);
			end
			if (load) begin
				rd_ptr_q <= (rd_ptr_q == QLAST) ? '0 : rd_ptr_q + PB'(1);
			end
			q_cnt_q <= q_cnt_q + CB'(job_valid) - CB'(load);
		end
	end

	// output stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (cur_done) begin
				cur_valid_q <= 1'b0;
			end else if (out_fire) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// output stage payload
	always_ff @(posedge clk) begin
		if (load) begin
			cur_job_q <= q_job_q[rd_ptr_q];
			cur_off_q <= q_off_q[rd_ptr_q];
		end
	end

	// word presented from the held job
	assign wr.valid        = cur_valid_q;
	assign wr.write_offset = cur_off_q[idx_q];
	assign wr.write_byte   = cur_job_q.data[idx_q];
	assign wr.is_header    = cur_job_q.hdr[idx_q];
	assign wr.last         = is_final;

	// checks
	`BRE_ASSERT_NOW(a_push_room, job_valid, q_cnt_q != QFULL, "job pushed into full queue")
	`BRE_ASSERT_NOW(a_push_nonempty, job_valid, job.cnt != 2'd0, "empty job pushed")
	`BRE_ASSERT_NOW(a_idx_range, cur_valid_q, idx_q < cur_job_q.cnt, "word index past job end")
	`BRE_ASSERT_NEXT(a_drain, cur_done && (q_cnt_q == '0), !cur_valid_q, "output stays valid after final word")

endmodule

FILE: hw/rtl/bitplane_rle_encoder.sv
// Bit-plane run-length encoder top level: configuration registers, front and back
// Throughput: one pixel per cycle; pix.ready drops only while the 4-job queue is full.
// A plane byte's job enters the queue at the edge that accepts its eighth pixel, and
// then moves to the single-word output stage once that is free; its up to 3 words
// follow one per cycle while wr.ready is high and never wait on a later pixel.
// Reset: plane_select 0, line_bytes 1, run state idle, queue and output stage empty.
`timescale 1ns / 1ps

module bitplane_rle_encoder #(
	parameter int MAX_LINE_BYTES = 128,
	parameter int OFFSET_BITS    = 20
) (
	input  logic      clk,
	input  logic      arst_n,
	bre_pix_if.sink   pix,
	bre_cfg_if.sink   cfg,
	bre_wr_if.source  wr
);

	logic [2:0] plane_select_q;
	logic [7:0] line_bytes_q;

	logic                                           space_ok;
	logic                                           job_valid;
	bre_pkg::job_t                                  job;
	logic [bre_pkg::JOB_SLOTS-1:0][OFFSET_BITS-1:0] job_off;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;

	// configuration registers, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_select_q <= 3'd0;
			line_bytes_q   <= 8'd1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				bre_pkg::REG_PLANE_SELECT: begin
					plane_select_q <= cfg.data[2:0];
				end
				bre_pkg::REG_LINE_BYTES: begin
					line_bytes_q <= cfg.data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	// byte assembly and run classification
	bre_front #(
		.MAX_LINE_BYTES (MAX_LINE_BYTES),
		.OFFSET_BITS    (OFFSET_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix          (pix),
		.plane_select (plane_select_q),
		.line_bytes   (line_bytes_q),
		.space_ok     (space_ok),
		.job_valid    (job_valid),
		.job          (job),
		.job_off      (job_off)
	);

	// job queue and word output
	bre_back #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_off   (job_off),
		.space_ok  (space_ok),
		.wr        (wr)
	);

endmodule
